>>> src/pqd_pkg.sv
// Shared types, constants and letter tables for the proquint decoder.
package pqd_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned POS_W = 3;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(23);
  localparam logic [POS_W-1:0] POS_DASH = POS_W'(5);
  localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_SHIFT4   = 3'd1,
    OP_SHIFT2   = 3'd2,
    OP_FAULT    = 3'd3,
    OP_END_FULL = 3'd4,
    OP_END_BAD  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] index;
  } token_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } letter_t;

  function automatic letter_t consonant_code(input logic [CHAR_W-1:0] c);
    letter_t r;
    r.hit = 1'b1;
    case (c)
      8'h62:   r.code = 4'h0; // b
      8'h64:   r.code = 4'h1; // d
      8'h66:   r.code = 4'h2; // f
      8'h67:   r.code = 4'h3; // g
      8'h68:   r.code = 4'h4; // h
      8'h6A:   r.code = 4'h5; // j
      8'h6B:   r.code = 4'h6; // k
      8'h6C:   r.code = 4'h7; // l
      8'h6D:   r.code = 4'h8; // m
      8'h6E:   r.code = 4'h9; // n
      8'h70:   r.code = 4'hA; // p
      8'h72:   r.code = 4'hB; // r
      8'h73:   r.code = 4'hC; // s
      8'h74:   r.code = 4'hD; // t
      8'h76:   r.code = 4'hE; // v
      8'h7A:   r.code = 4'hF; // z
      default: begin
        r.hit = 1'b0;
        r.code = 4'h0;
      end
    endcase
    return r;
  endfunction

  function automatic letter_t vowel_code(input logic [CHAR_W-1:0] c);
    letter_t r;
    r.hit = 1'b1;
    case (c)
      8'h61:   r.code = 4'h0; // a
      8'h69:   r.code = 4'h1; // i
      8'h6F:   r.code = 4'h2; // o
      8'h75:   r.code = 4'h3; // u
      default: begin
        r.hit = 1'b0;
        r.code = 4'h0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> src/proquint_decoder_64.sv
// Top level of the streaming 64-bit proquint decoder.
// One character is taken per cycle unless in_stall is high. Each character is
// classified at once and queued in a two-entry token queue; the back end drains
// one token per cycle into the accumulator, holding an end token while a result
// waits behind out_stall. A zero byte ends the string and yields one result
// (value, ok, fault_position) in the output register as its token leaves the
// queue; value and fault_position are zero when not applicable. in_stall rises
// only when the queue is full, which happens only while a result so waits.
module proquint_decoder_64 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pqd_pkg::CHAR_W-1:0]    char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pqd_pkg::VALUE_W-1:0]   value,
  output logic                          ok,
  output logic [pqd_pkg::INDEX_W-1:0]   fault_position
);
  import pqd_pkg::*;

  token_t front_tok;
  token_t head_tok;
  logic   full;
  logic   take;
  logic   head_valid;
  logic   pop;

  assign in_stall = full;
  assign take = in_valid && !full;

  pqd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (char_in),
    .tok     (front_tok)
  );

  pqd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_tok   (front_tok),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  pqd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_tok       (head_tok),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .ok             (ok),
    .fault_position (fault_position)
  );

endmodule

>>> src/pqd_front.sv
// Front end: tracks character position and classifies each character into a token.
module pqd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [pqd_pkg::CHAR_W-1:0]   char_in,
  output pqd_pkg::token_t              tok
);
  import pqd_pkg::*;

  logic [INDEX_W-1:0] char_index;
  logic [POS_W-1:0]   pos;
  logic [INDEX_W-1:0] char_index_next;
  logic [POS_W-1:0]   pos_next;
  letter_t            cons;
  letter_t            vow;

  always_comb begin
    cons = consonant_code(char_in);
    vow = vowel_code(char_in);
    tok.index = char_index;
    tok.code = '0;
    tok.op = OP_NOP;
    char_index_next = char_index + INDEX_W'(1);
    pos_next = (pos == POS_DASH) ? '0 : pos + POS_W'(1);
    if (char_in == CHAR_NUL) begin
      tok.op = (char_index == LAST_INDEX) ? OP_END_FULL : OP_END_BAD;
      char_index_next = '0;
      pos_next = '0;
    end else if (char_index >= LAST_INDEX) begin
      tok.op = OP_FAULT;
      tok.index = LAST_INDEX;
      char_index_next = LAST_INDEX;
      pos_next = pos;
    end else if (pos == POS_DASH) begin
      tok.op = (char_in == CHAR_DASH) ? OP_NOP : OP_FAULT;
    end else if (pos[0]) begin
      tok.op = vow.hit ? OP_SHIFT2 : OP_FAULT;
      tok.code = vow.code;
    end else begin
      tok.op = cons.hit ? OP_SHIFT4 : OP_FAULT;
      tok.code = cons.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_index <= '0;
      pos <= '0;
    end else if (take) begin
      char_index <= char_index_next;
      pos <= pos_next;
    end
  end

endmodule

>>> src/pqd_queue.sv
// Two-entry token queue between front and back end.
module pqd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pqd_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pqd_pkg::token_t head_tok
);
  import pqd_pkg::*;

  token_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count[1];
  assign head_valid = (count != 2'd0);
  assign head_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/pqd_back.sv
// Back end: accumulates the value, tracks the first fault and holds the result register.
module pqd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  pqd_pkg::token_t               head_tok,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pqd_pkg::VALUE_W-1:0]   value,
  output logic                          ok,
  output logic [pqd_pkg::INDEX_W-1:0]   fault_position
);
  import pqd_pkg::*;

  logic [VALUE_W-1:0] accumulator;
  logic               fault_seen;
  logic [INDEX_W-1:0] fault_index;
  logic               is_end;
  logic               slot_free;
  logic               good;
  logic [INDEX_W-1:0] first_fault;

  assign is_end = (head_tok.op == OP_END_FULL) || (head_tok.op == OP_END_BAD);
  assign slot_free = !out_valid || !out_stall;
  assign pop = head_valid && (!is_end || slot_free);
  assign good = (head_tok.op == OP_END_FULL) && !fault_seen;
  assign first_fault = fault_seen ? fault_index : head_tok.index;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      fault_seen <= 1'b0;
      fault_index <= '0;
    end else if (pop) begin
      case (head_tok.op)
        OP_SHIFT4: if (!fault_seen) accumulator <= {accumulator[VALUE_W-5:0], head_tok.code};
        OP_SHIFT2: if (!fault_seen) accumulator <= {accumulator[VALUE_W-3:0], head_tok.code[1:0]};
        OP_FAULT: begin
          fault_seen <= 1'b1;
          fault_index <= first_fault;
        end
        OP_END_FULL, OP_END_BAD: begin
          accumulator <= '0;
          fault_seen <= 1'b0;
          fault_index <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      value <= good ? accumulator : '0;
      ok <= good;
      fault_position <= good ? '0 : first_fault;
    end
  end

endmodule

>>> test/testbench.sv
// Testbench for proquint_decoder_64: directed and random strings, self-checking.
`timescale 1ns / 100ps

module testbench;
  import pqd_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 20;
  localparam logic [POS_W-1:0] SLOT_VOWEL_A = POS_W'(1);
  localparam logic [POS_W-1:0] SLOT_VOWEL_B = POS_W'(3);
  localparam string CONSONANTS = "bdfghjklmnprstvz";
  localparam string VOWELS = "aiou";
  localparam string SYMBOLS = "bdfghjklmnprstvzaiou-";

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic [INDEX_W-1:0] fault_position;
  } decode_result_t;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CHAR_W-1:0]   char_in = CHAR_NUL;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  value;
  logic                ok;
  logic [INDEX_W-1:0]  fault_position;
  logic                stall_hold_req = 1'b0;

  decode_result_t      decoded_q[$];
  logic [INDEX_W-1:0]  str_index = '0;
  logic [VALUE_W-1:0]  str_value = '0;
  logic                str_faulted = 1'b0;
  logic [INDEX_W-1:0]  str_fault_at = '0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;

  proquint_decoder_64 i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_in        (char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .ok             (ok),
    .fault_position (fault_position)
  );

  always #1 clk = ~clk;

  // Letter code is its position in the alphabet string, -1 if absent.
  function automatic int letter_code(input string set, input logic [CHAR_W-1:0] c);
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void flag_fault();
    if (!str_faulted) begin
      str_faulted = 1'b1;
      str_fault_at = str_index;
    end
  endfunction

  function automatic void decode_char(input logic [CHAR_W-1:0] c);
    logic good;
    logic [POS_W-1:0] slot;
    int code;
    decode_result_t r;
    if (c == CHAR_NUL) begin
      good = (str_index == LAST_INDEX) && !str_faulted;
      if (str_index != LAST_INDEX) flag_fault();
      r.value = good ? str_value : '0;
      r.ok = good;
      r.fault_position = good ? '0 : str_fault_at;
      decoded_q.push_back(r);
      str_index = '0;
      str_value = '0;
      str_faulted = 1'b0;
      str_fault_at = '0;
    end else if (str_index >= LAST_INDEX) begin
      flag_fault();
      str_index = LAST_INDEX;
    end else begin
      slot = POS_W'(str_index % INDEX_W'(6));
      if (slot == POS_DASH) begin
        if (c != CHAR_DASH) flag_fault();
      end else if (slot == SLOT_VOWEL_A || slot == SLOT_VOWEL_B) begin
        code = letter_code(VOWELS, c);
        if (code < 0) flag_fault();
        else if (!str_faulted) str_value = (str_value << 2) | VALUE_W'(code);
      end else begin
        code = letter_code(CONSONANTS, c);
        if (code < 0) flag_fault();
        else if (!str_faulted) str_value = (str_value << 4) | VALUE_W'(code);
      end
      str_index = str_index + INDEX_W'(1);
    end
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] proper_char(input int i);
    logic [POS_W-1:0] slot;
    slot = POS_W'(i % 6);
    if (slot == POS_DASH) return CHAR_DASH;
    if (slot == SLOT_VOWEL_A || slot == SLOT_VOWEL_B)
      return VOWELS[$urandom_range(VOWELS.len() - 1)];
    return CONSONANTS[$urandom_range(CONSONANTS.len() - 1)];
  endfunction

  // Mostly well-formed strings; the rest corrupted, cut short, overlong or noise.
  function automatic char_q_t build_string();
    char_q_t s;
    int kind;
    int n;
    s = {};
    for (int i = 0; i < int'(LAST_INDEX); i++) s.push_back(proper_char(i));
    kind = $urandom_range(99);
    if (kind >= 95) begin
      s = {};
      repeat ($urandom_range(30)) s.push_back(CHAR_W'($urandom_range(1, 255)));
    end else if (kind >= 85) begin
      repeat ($urandom_range(1, 4)) s.push_back(CHAR_W'($urandom_range(1, 255)));
    end else if (kind >= 75) begin
      n = $urandom_range(int'(LAST_INDEX) - 1);
      while (s.size() > n) void'(s.pop_back());
    end else if (kind >= 60) begin
      n = $urandom_range(int'(LAST_INDEX) - 1);
      if ($urandom_range(1)) s[n] = CHAR_W'($urandom_range(1, 255));
      else s[n] = SYMBOLS[$urandom_range(SYMBOLS.len() - 1)];
    end
    s.push_back(CHAR_NUL);
    return s;
  endfunction

  task automatic send_random_strings(input int n_chars);
    char_q_t s;
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      s = build_string();
      foreach (s[i]) send_char(s[i]);
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    send_char(CHAR_NUL);
    send_text("zuzuz-zuzuz-zuzuz-zuzuz");
    send_char(CHAR_NUL);
    send_text("bxk-q");
    send_char(CHAR_NUL);
    send_text("babab-babab-babab-babab");
    send_char(8'hFF);
    send_char(CHAR_NUL);
    wait_drained();
  endtask

  task automatic test_free_flow();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_strings(300);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 80;
    recv_stall_pct = 0;
    send_random_strings(300);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    recv_stall_pct = 80;
    send_random_strings(300);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 26;
    recv_stall_pct = 26;
    send_random_strings(300);
  endtask

  // Long output hold while input keeps coming, so the input stalls.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    stall_hold_req <= 1'b1;
    @(posedge clk);
    stall_hold_req <= 1'b0;
    send_random_strings(150);
    wait_drained();
  endtask

  always @(posedge clk) begin : rx
    decode_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      if (!rst && out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected transfer: value %h ok %b fault_position %0d",
                 value, ok, fault_position);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (value !== want.value) begin
            $error("value: expected %h, got %h", want.value, value);
            mismatches++;
          end
          if (ok !== want.ok) begin
            $error("ok: expected %b, got %b", want.ok, ok);
            mismatches++;
          end
          if (fault_position !== want.fault_position) begin
            $error("fault_position: expected %0d, got %0d",
                   want.fault_position, fault_position);
            mismatches++;
          end
        end
      end
      if (stall_hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_free_flow();
    test_sender_gaps();
    test_backpressure();
    test_receiver_stalls();
    test_both_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pqd_pkg.sv
src/pqd_front.sv
src/pqd_queue.sv
src/pqd_back.sv
src/proquint_decoder_64.sv
test/testbench.sv
